>>> src/bil_pkg.sv
// Shared types and constants for the bounded indexed list.
// Used by bil_cell, bil_ctrl and the bounded_indexed_list top level.
package bil_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int POS_W = 5;
  localparam int WORD_W = 32;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic [CNT_W-1:0] count_t;

  localparam logic [3:0] OP_ADD_FIRST    = 4'd0;
  localparam logic [3:0] OP_ADD_LAST     = 4'd1;
  localparam logic [3:0] OP_ADD_AT       = 4'd2;
  localparam logic [3:0] OP_REMOVE_FIRST = 4'd3;
  localparam logic [3:0] OP_REMOVE_LAST  = 4'd4;
  localparam logic [3:0] OP_REMOVE_AT    = 4'd5;
  localparam logic [3:0] OP_GET_AT       = 4'd6;
  localparam logic [3:0] OP_PEEK_FIRST   = 4'd7;
  localparam logic [3:0] OP_PEEK_LAST    = 4'd8;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [3:0]              opcode;
    logic [POS_W-1:0]        position;
    logic signed [WORD_W-1:0] value_in;
  } req_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] read_value;
    logic [1:0]               status;
    logic [POS_W-1:0]         occupancy;
  } rsp_t;

  // Command broadcast to every slot cell in a cycle.
  typedef struct packed {
    logic  insert;
    logic  remove;
    word_t value;
  } cell_cmd_t;

endpackage

>>> src/bil_cell.sv
// One slot of the list: holds a word and shifts with its neighbors.
// Depends on bil_pkg for the word and command types.
module bil_cell (
  input  logic               clk,
  input  bil_pkg::cell_cmd_t cmd,
  input  logic               sel,
  input  logic               past_in,
  output logic               past_out,
  input  bil_pkg::word_t     left_word,
  input  bil_pkg::word_t     right_word,
  output bil_pkg::word_t     word
);
  import bil_pkg::*;

  // past_in is high when the selected position lies before this cell.
  assign past_out = past_in | sel;

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      if (sel) begin
        word <= cmd.value;
      end else if (past_in) begin
        word <= left_word;
      end
    end else if (cmd.remove) begin
      if (sel || past_in) begin
        word <= right_word;
      end
    end
  end

endmodule

>>> src/bil_ctrl.sv
// Request decode, element count and result register of the list.
// Depends on bil_pkg; drives the command and position select of the slot cells.
module bil_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  bil_pkg::req_t      req,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output bil_pkg::rsp_t      rsp,
  input  bil_pkg::word_t     words [bil_pkg::DEPTH],
  output bil_pkg::cell_cmd_t cmd,
  output logic [bil_pkg::DEPTH-1:0] sel
);
  import bil_pkg::*;

  count_t           count;
  count_t           count_next;
  logic [POS_W-1:0] eff_pos;
  logic             do_ins;
  logic             do_rem;
  logic [1:0]       st;
  word_t            rv;
  word_t            rd_word;
  logic             full;
  logic             empty;
  logic             accept;

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = count >= count_t'(DEPTH);
  assign empty     = count == '0;
  assign rd_word   = words[eff_pos[IDX_W-1:0]];

  always_comb begin
    case (req.opcode)
      OP_ADD_FIRST, OP_REMOVE_FIRST, OP_PEEK_FIRST: begin
        eff_pos = '0;
      end
      OP_ADD_LAST: begin
        eff_pos = POS_W'(count);
      end
      OP_REMOVE_LAST, OP_PEEK_LAST: begin
        eff_pos = POS_W'(count - count_t'(1));
      end
      default: begin
        eff_pos = req.position;
      end
    endcase
  end

  always_comb begin
    do_ins  = 1'b0;
    do_rem  = 1'b0;
    st      = ST_RANGE;
    rv      = '1;
    case (req.opcode)
      OP_ADD_FIRST, OP_ADD_LAST: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_ADD_AT: begin
        if (POS_W'(req.position) > POS_W'(count)) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          do_ins = 1'b1;
        end
      end
      OP_REMOVE_FIRST, OP_PEEK_FIRST: begin
        if (!empty) begin
          do_rem = (req.opcode == OP_REMOVE_FIRST);
          st     = ST_OK;
          rv     = rd_word;
        end
      end
      OP_REMOVE_LAST, OP_PEEK_LAST: begin
        if (!empty) begin
          do_rem = (req.opcode == OP_REMOVE_LAST);
          st     = ST_OK;
          rv     = rd_word;
        end
      end
      OP_REMOVE_AT, OP_GET_AT: begin
        if (POS_W'(req.position) < POS_W'(count)) begin
          do_rem = (req.opcode == OP_REMOVE_AT);
          st     = ST_OK;
          rv     = rd_word;
        end
      end
      default: begin
      end
    endcase
    if (do_ins) begin
      st = ST_OK;
      rv = '0;
    end
  end

  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + count_t'(1);
    end else if (do_rem) begin
      count_next = count - count_t'(1);
    end
  end

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      sel[i] = (eff_pos == POS_W'(i));
    end
  end

  assign cmd.insert = accept && do_ins;
  assign cmd.remove = accept && do_rem;
  assign cmd.value  = req.value_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp.read_value <= rv;
      rsp.status     <= st;
      rsp.occupancy  <= POS_W'(count_next);
    end
  end

endmodule

>>> src/bounded_indexed_list.sv
// Top level of the bounded indexed list: a chain of slot cells and its control.
// Depends on bil_pkg, bil_cell and bil_ctrl.
//
// A bounded list of up to 16 signed 32-bit words, usable as a double-ended
// queue. Each request transfer carries one operation (add at front, back or
// position; remove at front, back or position; read at position; peek at
// either end) and produces exactly one response transfer with the word read,
// a status and the occupancy after the operation. Every slot cell decides on
// its own to hold, load the new word or take its neighbor's word, so inserts
// and removes shift the list from the given position onward in the cycle the
// request is taken. A response sits in an output register, and a new request
// is taken when none is pending or in the cycle the pending one is taken,
// giving one operation per cycle when the consumer keeps up.
module bounded_indexed_list (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  bil_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output bil_pkg::rsp_t rsp
);
  import bil_pkg::*;

  word_t                words [DEPTH];
  cell_cmd_t            cmd;
  logic [DEPTH-1:0]     sel;
  logic [DEPTH:0]       past;

  bil_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .words     (words),
    .cmd       (cmd),
    .sel       (sel)
  );

  assign past[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t left_word;
    word_t right_word;

    if (i == 0) begin : g_first
      assign left_word = '0;
    end else begin : g_mid_l
      assign left_word = words[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_word = '0;
    end else begin : g_mid_r
      assign right_word = words[i+1];
    end

    bil_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .sel        (sel[i]),
      .past_in    (past[i]),
      .past_out   (past[i+1]),
      .left_word  (left_word),
      .right_word (right_word),
      .word       (words[i])
    );
  end

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the bounded indexed list (bounded_indexed_list).
// Depends on bil_pkg and the RTL under src; it keeps its own copy of the list
// contents to predict each response.
module tb_top;
  import bil_pkg::*;

  // Opcodes with no meaning; the block must answer them with a range error.
  localparam logic [3:0] OP_FIRST_UNUSED = 4'd9;
  localparam logic [3:0] OP_LAST_UNUSED  = 4'd15;
  localparam logic signed [WORD_W-1:0] ERR_WORD = -1;

  logic  clk;
  logic  rst = 1'b1;
  logic  req_valid = 1'b0;
  logic  req_ready;
  req_t  req = '0;
  logic  rsp_valid;
  logic  rsp_ready = 1'b0;
  rsp_t  rsp;

  // Local copy of the list held by the block.
  logic [WORD_W-1:0] list_words [DEPTH];
  int                list_count = 0;

  rsp_t predicted_replies [$];
  rsp_t want_rsp;
  int   mismatch_count = 0;
  int   send_idle_pct = 0;
  int   rsp_idle_pct = 0;
  int   rsp_hold_left = 0;

  bounded_indexed_list dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Applies one operation to the local list and returns the response it should give.
  function automatic rsp_t apply_list_op(input req_t r);
    rsp_t res;
    int   pos;
    logic full;
    logic empty;
    res.read_value = ERR_WORD;
    res.status = ST_RANGE;
    pos = r.position;
    full = (list_count >= DEPTH);
    empty = (list_count == 0);
    case (r.opcode)
      OP_ADD_FIRST, OP_ADD_LAST, OP_ADD_AT: begin
        if (r.opcode == OP_ADD_FIRST) begin
          pos = 0;
        end else if (r.opcode == OP_ADD_LAST) begin
          pos = list_count;
        end
        // For add_at the range check wins over the full check.
        if (pos > list_count) begin
          res.status = ST_RANGE;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          for (int i = list_count; i > pos; i--) begin
            list_words[i] = list_words[i-1];
          end
          list_words[pos] = r.value_in;
          list_count++;
          res.read_value = '0;
          res.status = ST_OK;
        end
      end
      OP_REMOVE_FIRST, OP_REMOVE_LAST, OP_REMOVE_AT: begin
        if (r.opcode == OP_REMOVE_FIRST) begin
          pos = 0;
        end else if (r.opcode == OP_REMOVE_LAST) begin
          pos = list_count - 1;
        end
        if (!empty && pos < list_count) begin
          res.read_value = list_words[pos];
          res.status = ST_OK;
          for (int i = pos; i + 1 < list_count; i++) begin
            list_words[i] = list_words[i+1];
          end
          list_count--;
        end
      end
      OP_GET_AT: begin
        if (pos < list_count) begin
          res.read_value = list_words[pos];
          res.status = ST_OK;
        end
      end
      OP_PEEK_FIRST: begin
        if (!empty) begin
          res.read_value = list_words[0];
          res.status = ST_OK;
        end
      end
      OP_PEEK_LAST: begin
        if (!empty) begin
          res.read_value = list_words[list_count-1];
          res.status = ST_OK;
        end
      end
      default: begin
      end
    endcase
    res.occupancy = list_count[POS_W-1:0];
    return res;
  endfunction

  function automatic req_t make_req(input logic [3:0] op, input int pos,
                                    input logic [WORD_W-1:0] val);
    req_t r;
    r.opcode = op;
    r.position = pos[POS_W-1:0];
    r.value_in = val;
    return r;
  endfunction

  // Builds a random request that drifts the fill level toward fill_goal.
  function automatic req_t random_req(input int fill_goal);
    int         roll;
    int         grow_pct;
    logic [3:0] op;
    int         pos;
    roll = $urandom_range(99);
    if (roll < 4) begin
      op = 4'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
    end else if (roll < 22) begin
      case ($urandom_range(2))
        0: op = OP_GET_AT;
        1: op = OP_PEEK_FIRST;
        default: op = OP_PEEK_LAST;
      endcase
    end else begin
      grow_pct = (list_count < fill_goal) ? 70 : 30;
      if ($urandom_range(99) < grow_pct) begin
        case ($urandom_range(2))
          0: op = OP_ADD_FIRST;
          1: op = OP_ADD_LAST;
          default: op = OP_ADD_AT;
        endcase
      end else begin
        case ($urandom_range(2))
          0: op = OP_REMOVE_FIRST;
          1: op = OP_REMOVE_LAST;
          default: op = OP_REMOVE_AT;
        endcase
      end
    end
    // Mostly positions up to the current count, sometimes anything the field holds.
    if ($urandom_range(9) == 0) begin
      pos = $urandom_range((1 << POS_W) - 1);
    end else begin
      pos = $urandom_range(list_count);
    end
    return make_req(op, pos, $urandom());
  endfunction

  // Offers one request and records its predicted response once the transfer happens.
  // Valid is left high so back-to-back requests need no second assignment.
  task automatic send_req(input req_t item);
    if ($urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (!req_ready);
    predicted_replies.push_back(apply_list_op(item));
  endtask

  task automatic wait_for_replies();
    req_valid <= 1'b0;
    @(posedge clk);
    while (predicted_replies.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic test_empty_list();
    send_req(make_req(OP_PEEK_FIRST, 0, $urandom()));
    send_req(make_req(OP_PEEK_LAST, 0, $urandom()));
    send_req(make_req(OP_REMOVE_FIRST, 0, $urandom()));
    send_req(make_req(OP_REMOVE_LAST, 0, $urandom()));
    send_req(make_req(OP_REMOVE_AT, 0, $urandom()));
    send_req(make_req(OP_GET_AT, 0, $urandom()));
    send_req(make_req(OP_ADD_AT, 1, $urandom()));
    send_req(make_req(OP_LAST_UNUSED, 0, $urandom()));
  endtask

  task automatic test_mixed_ops();
    send_req(make_req(OP_ADD_AT, 0, 32'h8000_0000));
    send_req(make_req(OP_ADD_LAST, 0, 32'h7FFF_FFFF));
    send_req(make_req(OP_ADD_FIRST, 0, 32'hFFFF_FFFF));
    send_req(make_req(OP_ADD_AT, 3, 32'h0000_0000));
    send_req(make_req(OP_ADD_AT, 1, 32'h5A5A_A5A5));
    send_req(make_req(OP_ADD_AT, 9, $urandom()));
    send_req(make_req(OP_GET_AT, 0, $urandom()));
    send_req(make_req(OP_GET_AT, 4, $urandom()));
    send_req(make_req(OP_GET_AT, 5, $urandom()));
    send_req(make_req(OP_GET_AT, 31, $urandom()));
    send_req(make_req(OP_PEEK_FIRST, 0, $urandom()));
    send_req(make_req(OP_PEEK_LAST, 0, $urandom()));
    send_req(make_req(OP_REMOVE_AT, 2, $urandom()));
    send_req(make_req(OP_REMOVE_AT, 31, $urandom()));
    send_req(make_req(OP_FIRST_UNUSED, 0, $urandom()));
    send_req(make_req(OP_REMOVE_FIRST, 0, $urandom()));
    send_req(make_req(OP_REMOVE_LAST, 0, $urandom()));
    send_req(make_req(OP_REMOVE_AT, 0, $urandom()));
    send_req(make_req(OP_REMOVE_LAST, 0, $urandom()));
  endtask

  task automatic test_full_list();
    while (list_count < DEPTH) begin
      send_req(make_req(OP_ADD_LAST, 0, $urandom()));
    end
    send_req(make_req(OP_ADD_FIRST, 0, $urandom()));
    send_req(make_req(OP_ADD_LAST, 0, $urandom()));
    send_req(make_req(OP_ADD_AT, DEPTH, $urandom()));
    send_req(make_req(OP_ADD_AT, DEPTH + 1, $urandom()));
    send_req(make_req(OP_GET_AT, DEPTH - 1, $urandom()));
    send_req(make_req(OP_GET_AT, DEPTH, $urandom()));
    send_req(make_req(OP_PEEK_LAST, 0, $urandom()));
    send_req(make_req(OP_REMOVE_AT, DEPTH - 1, $urandom()));
    send_req(make_req(OP_ADD_AT, DEPTH - 1, 32'hFFFF_FFFF));
    send_req(make_req(OP_ADD_AT, 0, $urandom()));
    while (list_count > 0) begin
      send_req(make_req(OP_REMOVE_FIRST, 0, $urandom()));
    end
    send_req(make_req(OP_REMOVE_FIRST, 0, $urandom()));
  endtask

  task automatic test_random_ops(input int n, input int send_pct, input int recv_pct);
    int fill_goal;
    send_idle_pct = send_pct;
    rsp_idle_pct = recv_pct;
    fill_goal = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 48 == 0) begin
        fill_goal = $urandom_range(DEPTH);
      end
      send_req(random_req(fill_goal));
    end
  endtask

  // The output stalls for a long stretch while requests keep coming,
  // so the block must hold off its input.
  task automatic test_stalled_output();
    send_idle_pct = 0;
    rsp_hold_left = 300;
    for (int k = 0; k < 24; k++) begin
      send_req(random_req(DEPTH / 2));
    end
  endtask

  task automatic test_sender_pause();
    wait_for_replies();
    for (int k = 0; k < 8; k++) begin
      send_req(random_req(DEPTH));
    end
    wait_for_replies();
  endtask

  always @(posedge clk) begin
    if (rsp_hold_left > 0) begin
      rsp_ready <= 1'b0;
      rsp_hold_left = rsp_hold_left - 1;
    end else begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) begin
      if (predicted_replies.size() == 0) begin
        $display("%0t: response transfer with none expected, got %h", $time, rsp);
        mismatch_count++;
      end else begin
        want_rsp = predicted_replies.pop_front();
        if (rsp.read_value !== want_rsp.read_value) begin
          $display("%0t: read_value expected %h, got %h", $time,
                   want_rsp.read_value, rsp.read_value);
          mismatch_count++;
        end
        if (rsp.status !== want_rsp.status) begin
          $display("%0t: status expected %0d, got %0d", $time,
                   want_rsp.status, rsp.status);
          mismatch_count++;
        end
        if (rsp.occupancy !== want_rsp.occupancy) begin
          $display("%0t: occupancy expected %0d, got %0d", $time,
                   want_rsp.occupancy, rsp.occupancy);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    send_idle_pct = 21;
    rsp_idle_pct = 72;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_list();
    test_mixed_ops();
    test_full_list();
    test_random_ops(600, 21, 72);
    test_stalled_output();
    test_random_ops(600, 72, 21);
    test_sender_pause();
    test_random_ops(600, 0, 0);
    wait_for_replies();
    repeat (8) @(posedge clk);
    if (predicted_replies.size() != 0) begin
      $display("%0t: %0d responses never arrived", $time, predicted_replies.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
